// ----- sv/pv_pkg.sv -----
// Shared constants for the population variance block.
// Depends on nothing; every other file but pv_ram refers to it by scoped names.
package pv_pkg;

   localparam int MAX_ITEMS = 1024;
   localparam int SAMPLE_W  = 16;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W     = SAMPLE_W + ADDR_W + 1;
   localparam int DIFF_W    = SAMPLE_W + 1;
   localparam int SQ_W      = 2 * SAMPLE_W;
   localparam int ACC_W     = SQ_W + ADDR_W;
   localparam int FRAC_W    = 8;
   localparam int DVD_W     = ACC_W + FRAC_W;
   localparam int VAR_W     = 40;

endpackage

// ----- sv/population_variance.sv -----
// Population variance of a set of signed samples, two passes over a sample RAM.
// Depends on pv_pkg, pv_ram, pv_div and pv_sqacc.
// Throughput: while a set loads, one sample is taken per cycle and busy stays low.
// After the closing sample the block stays busy while the one-bit-per-cycle divider
// runs twice, for the mean and then the variance, with one RAM read per sample between.
// Reset clears the sum, count and flag; the RAM keeps its contents. No stall on results.
module population_variance (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [pv_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                        req_last,
   output logic                        rsp_valid,
   output logic [pv_pkg::VAR_W-1:0]    rsp_variance_value,
   output logic                        rsp_status
);

   typedef enum logic [2:0] {
      S_LOAD,
      S_MEAN_GO,
      S_MEAN_WAIT,
      S_PASS,
      S_VAR_GO,
      S_VAR_WAIT
   } state_type;

   state_type                          state_ff, state_in;
   logic signed [pv_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [pv_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic                               ovf_ff, ovf_in;
   logic [pv_pkg::COUNT_W-1:0]         idx_ff, idx_in;
   logic                               rd_pend_ff, rd_pend_in;
   logic signed [pv_pkg::SAMPLE_W-1:0] mean_ff, mean_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [pv_pkg::VAR_W-1:0]           var_ff, var_in;
   logic                               status_ff, status_in;

   logic                               accept;
   logic                               has_room;
   logic                               wr_en;
   logic                               rd_en;
   logic [pv_pkg::SUM_W-1:0]           abs_sum;
   logic                               div_start;
   logic [pv_pkg::DVD_W-1:0]           div_dividend;
   logic                               div_busy;
   logic                               div_done;
   logic [pv_pkg::DVD_W-1:0]           div_quotient;
   logic [pv_pkg::SAMPLE_W-1:0]        rd_data;
   logic [pv_pkg::ACC_W-1:0]           sq_acc;
   logic                               sq_busy;

   assign busy     = (state_ff != S_LOAD);
   assign accept   = start && !busy;
   assign has_room = (count_ff < pv_pkg::COUNT_W'(pv_pkg::MAX_ITEMS));
   assign wr_en    = accept && has_room;
   assign rd_en    = (state_ff == S_PASS) && (idx_ff < count_ff);
   assign abs_sum  = sum_ff[pv_pkg::SUM_W-1] ? pv_pkg::SUM_W'(-sum_ff) : pv_pkg::SUM_W'(sum_ff);
   assign div_start = (state_ff == S_MEAN_GO) || (state_ff == S_VAR_GO);
   assign div_dividend = (state_ff == S_MEAN_GO) ? pv_pkg::DVD_W'(abs_sum)
                                                 : {sq_acc, pv_pkg::FRAC_W'(0)};

   pv_ram #(
      .WIDTH (pv_pkg::SAMPLE_W),
      .DEPTH (pv_pkg::MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[pv_pkg::ADDR_W-1:0]),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[pv_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   pv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   pv_sqacc u_sqacc (
      .clock    (clock),
      .reset    (reset),
      .clear    (state_ff == S_MEAN_GO),
      .in_valid (rd_pend_ff),
      .rd_data  (rd_data),
      .mean     (mean_ff),
      .acc      (sq_acc),
      .busy     (sq_busy)
   );

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      rd_pend_in   = rd_en;
      mean_in      = mean_ff;
      rsp_valid_in = 1'b0;
      var_in       = var_ff;
      status_in    = status_ff;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (has_room) begin
                  sum_in   = sum_ff + pv_pkg::SUM_W'($signed(req_sample));
                  count_in = count_ff + pv_pkg::COUNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  state_in = S_MEAN_GO;
               end
            end
         end
         S_MEAN_GO: begin
            state_in = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (div_done) begin
               mean_in = sum_ff[pv_pkg::SUM_W-1]
                         ? -$signed(div_quotient[pv_pkg::SAMPLE_W-1:0])
                         : $signed(div_quotient[pv_pkg::SAMPLE_W-1:0]);
               idx_in   = '0;
               state_in = S_PASS;
            end
         end
         S_PASS: begin
            if (rd_en) begin
               idx_in = idx_ff + pv_pkg::COUNT_W'(1);
            end else if (!rd_pend_ff && !sq_busy) begin
               state_in = S_VAR_GO;
            end
         end
         S_VAR_GO: begin
            state_in = S_VAR_WAIT;
         end
         S_VAR_WAIT: begin
            if (div_done) begin
               var_in       = div_quotient[pv_pkg::VAR_W-1:0];
               status_in    = ovf_ff;
               rsp_valid_in = 1'b1;
               sum_in       = '0;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      mean_ff   <= mean_in;
      var_ff    <= var_in;
      status_ff <= status_in;
      if (reset) begin
         state_ff     <= S_LOAD;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_variance_value = var_ff;
   assign rsp_status         = status_ff;

   // A result follows only the completion of the second division.
   a_rsp_after_div : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff == S_VAR_WAIT) && $past(div_done) && !busy))
      else $error("result transaction without a completed variance division");

   // The fill count never passes the store depth.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= pv_pkg::COUNT_W'(pv_pkg::MAX_ITEMS))
      else $error("sample count beyond store depth");

   // The shared divider is never restarted while it is still iterating.
   a_div_free : assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // The variance division starts only once the squaring pipeline has drained.
   a_drained : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VAR_GO) |-> (!sq_busy && !rd_pend_ff && idx_ff == count_ff))
      else $error("variance division started before the second pass finished");

endmodule

// ----- sv/pv_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module pv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pv_div.sv -----
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on pv_pkg for the dividend and divisor widths.
module pv_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pv_pkg::DVD_W-1:0]   dividend,
   input  logic [pv_pkg::COUNT_W-1:0] divisor,
   output logic                       busy,
   output logic                       done,
   output logic [pv_pkg::DVD_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(pv_pkg::DVD_W + 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [pv_pkg::DVD_W-1:0]   quo_ff, quo_in;
   logic [pv_pkg::COUNT_W-1:0] rem_ff, rem_in;
   logic [pv_pkg::COUNT_W-1:0] div_ff, div_in;
   logic [pv_pkg::COUNT_W:0]   trial;
   logic [pv_pkg::COUNT_W:0]   trial_sub;
   logic                       fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[pv_pkg::DVD_W-1]};
      fits      = (trial >= {1'b0, div_ff});
      trial_sub = trial - {1'b0, div_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(pv_pkg::DVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[pv_pkg::COUNT_W-1:0] : trial[pv_pkg::COUNT_W-1:0];
         quo_in = {quo_ff[pv_pkg::DVD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- sv/pv_sqacc.sv -----
// Squared-deviation pipeline: difference from the mean, square, accumulate.
// Depends on pv_pkg for the sample, difference and accumulator widths.
module pv_sqacc (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  logic                              in_valid,
   input  logic [pv_pkg::SAMPLE_W-1:0]       rd_data,
   input  logic signed [pv_pkg::SAMPLE_W-1:0] mean,
   output logic [pv_pkg::ACC_W-1:0]          acc,
   output logic                              busy
);

   logic                               v1_ff, v1_in;
   logic                               v2_ff, v2_in;
   logic signed [pv_pkg::DIFF_W-1:0]   diff_ff, diff_in;
   logic signed [2*pv_pkg::DIFF_W-1:0] prod_full;
   logic [pv_pkg::SQ_W-1:0]            prod_ff, prod_in;
   logic [pv_pkg::ACC_W-1:0]           acc_ff, acc_in;

   always_comb begin
      diff_in   = pv_pkg::DIFF_W'($signed(rd_data)) - pv_pkg::DIFF_W'(mean);
      prod_full = diff_ff * diff_ff;
      prod_in   = prod_full[pv_pkg::SQ_W-1:0];
      v1_in     = in_valid;
      v2_in     = v1_ff;
      acc_in    = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + pv_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         acc_ff <= acc_in;
      end
   end

   assign acc  = acc_ff;
   assign busy = v1_ff | v2_ff;

endmodule

// ----- tb/pv_variance_checker.sv -----
`timescale 1ns / 1ps
// Watches the sample and result channels of population_variance, works out the expected
// variance and status of every closed set, and compares them with what the block returns.
// Depends on pv_pkg for the field widths and the store depth.
module pv_variance_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [pv_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                        req_last,
   input  logic                        rsp_valid,
   input  logic [pv_pkg::VAR_W-1:0]    rsp_variance_value,
   input  logic                        rsp_status,
   output int                          error_count,
   output int                          outstanding
);

   typedef struct {
      logic [pv_pkg::VAR_W-1:0] variance_value;
      logic                     status;
   } variance_result_type;

   logic signed [pv_pkg::SAMPLE_W-1:0] held_samples [pv_pkg::MAX_ITEMS];
   longint                             sample_sum;
   int                                 sample_count;
   bit                                 dropped_seen;
   variance_result_type                pending_results [$];
   variance_result_type                oldest;
   variance_result_type                predicted;
   int                                 errors;

   function automatic logic [pv_pkg::VAR_W-1:0] predict_variance();
      longint          mean;
      longint          diff;
      longint unsigned square_sum;
      mean       = sample_sum / longint'(sample_count);
      square_sum = 0;
      for (int i = 0; i < sample_count; i++) begin
         diff       = longint'(held_samples[i]) - mean;
         square_sum += longint'(diff * diff);
      end
      return (square_sum << 8) / longint'(sample_count);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         sample_sum   = 0;
         sample_count = 0;
         dropped_seen = 1'b0;
         pending_results.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $display("%0t result with no closed set waiting: variance %0d, flag %0b",
                        $time, rsp_variance_value, rsp_status);
               errors++;
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_variance_value !== oldest.variance_value) begin
                  $display("%0t variance mismatch: expected %0d, actual %0d",
                           $time, oldest.variance_value, rsp_variance_value);
                  errors++;
               end
               if (rsp_status !== oldest.status) begin
                  $display("%0t dropped-sample flag mismatch: expected %0b, actual %0b",
                           $time, oldest.status, rsp_status);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            if (sample_count < pv_pkg::MAX_ITEMS) begin
               held_samples[sample_count] = $signed(req_sample);
               sample_sum += longint'($signed(req_sample));
               sample_count++;
            end else begin
               dropped_seen = 1'b1;
            end
            if (req_last) begin
               predicted.variance_value = predict_variance();
               predicted.status         = dropped_seen;
               pending_results.push_back(predicted);
               sample_sum   = 0;
               sample_count = 0;
               dropped_seen = 1'b0;
            end
         end
      end
      outstanding <= pending_results.size();
      error_count <= errors;
   end

endmodule

// ----- tb/tb_population_variance.sv -----
`timescale 1ns / 1ps
// Top of the population_variance testbench: clock, reset and sample stimulus, with the
// checker beside the block. Depends on pv_pkg, population_variance and pv_variance_checker.
module tb_population_variance;

   localparam int TAIL_CYCLES = pv_pkg::MAX_ITEMS + 2 * pv_pkg::DVD_W + 64;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [pv_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                        req_last = 1'b0;
   logic                        rsp_valid;
   logic [pv_pkg::VAR_W-1:0]    rsp_variance_value;
   logic                        rsp_status;
   int                          error_count;
   int                          outstanding;

   population_variance dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_sample         (req_sample),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_variance_value (rsp_variance_value),
      .rsp_status         (rsp_status)
   );

   pv_variance_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_sample         (req_sample),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_variance_value (rsp_variance_value),
      .rsp_status         (rsp_status),
      .error_count        (error_count),
      .outstanding        (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int next_gap(input bit burst);
      int roll;
      roll = $urandom_range(0, 99);
      if (burst || roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 60);
   endfunction

   function automatic logic [pv_pkg::SAMPLE_W-1:0] pick_sample(input int style,
                                                              input logic [15:0] centre);
      case (style)
         0: return 16'($urandom);
         1: return centre + 16'($urandom_range(0, 15)) - 16'd8;
         default: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'hFFFF;
               default: return 16'h0000;
            endcase
         end
      endcase
   endfunction

   // Presents one sample and holds it until the block takes the transaction.
   task automatic send_sample(input logic [pv_pkg::SAMPLE_W-1:0] value, input bit closes,
                              input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_sample <= value;
      req_last   <= closes;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic send_set(input int length, input int style, input bit burst);
      logic [15:0] centre;
      centre = 16'($urandom);
      for (int i = 0; i < length; i++) begin
         send_sample(pick_sample(style, centre), i == length - 1, next_gap(burst));
      end
   endtask

   initial begin
      int sent;
      int length;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      send_sample(16'h7FFF, 1'b1, 0);
      send_sample(16'h8000, 1'b0, 0);
      send_sample(16'h7FFF, 1'b1, 0);
      send_sample(-16'sd3, 1'b0, 1);
      send_sample(-16'sd2, 1'b0, 0);
      send_sample(-16'sd2, 1'b1, 0);
      for (int i = 0; i < 4; i++) begin
         send_sample(16'h8000, i == 3, 0);
      end
      send_sample(16'h0000, 1'b0, 2);
      send_sample(16'h0001, 1'b1, 0);
      send_sample(16'h7FFF, 1'b0, 0);
      send_sample(16'h8000, 1'b0, 0);
      send_sample(16'h7FFF, 1'b0, 0);
      send_sample(16'h8000, 1'b0, 0);
      send_sample(16'h0000, 1'b1, 0);
      wait_for_results();

      // A set that fills the store exactly, then one whose tail, closing sample
      // included, no longer fits and is dropped.
      send_set(pv_pkg::MAX_ITEMS, 0, $urandom_range(0, 1) == 1);
      send_set(pv_pkg::MAX_ITEMS + 2, 0, 1'b0);
      wait_for_results();

      sent = 0;
      while (sent < 600) begin
         length = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12)
                                               : $urandom_range(13, 80);
         send_set(length, $urandom_range(0, 2), $urandom_range(0, 3) == 0);
         sent += length;
         if ($urandom_range(0, 7) == 0) begin
            wait_for_results();
         end
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
